// ===== src/ges_pkg.sv =====
// Package for the Gaussian elimination solver.
// Holds the default sizes, the controller state type, the command and
// status structs, and the saturating fixed-point helpers.
package ges_pkg;

	localparam int MAX_UNKNOWNS_DEF  = 8;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int DATA_W            = 32;
	localparam int CFG_W             = 4;
	localparam int IDX_W             = 3;
	localparam int SIZE_RESET        = 8;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PIV,
		ST_CHK,
		ST_DIV,
		ST_RD,
		ST_MUL,
		ST_RND,
		ST_WR,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		FAC_HOLD,
		FAC_ZERO,
		FAC_DIV
	} fac_op_t;

	typedef struct packed {
		logic    rd;
		logic    we;
		logic    wsel_load;
		fac_op_t fac_op;
		logic    sol_we;
		logic    div_start;
		logic    out_load;
		logic    out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic piv_zero;
		logic div_done;
	} dp_stat_t;

	function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] a);
		mag32 = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_mag(input logic neg,
			input logic [63:0] mag);
		logic [63:0] lim;
		lim = 64'(1) << (DATA_W - 1);
		if (neg) begin
			if (mag >= lim)
				sat_mag = {1'b1, {(DATA_W-1){1'b0}}};
			else
				sat_mag = DATA_W'(-mag);
		end else begin
			if (mag > lim - 64'd1)
				sat_mag = {1'b0, {(DATA_W-1){1'b1}}};
			else
				sat_mag = DATA_W'(mag);
		end
	endfunction

	function automatic logic signed [DATA_W-1:0] sub_sat(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		logic [DATA_W:0] d;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (d[DATA_W] != d[DATA_W-1])
			sub_sat = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		else
			sub_sat = d[DATA_W-1:0];
	endfunction

endpackage

// ===== src/ges_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module ges_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 72
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ===== src/ges_div.sv =====
// Radix-2 restoring divider for fixed-point quotients, rounded and saturated.
// Depends on ges_pkg.
module ges_div import ges_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] num,
	input  logic signed [DATA_W-1:0] den,
	output logic                     done,
	output logic signed [DATA_W-1:0] quo
);

	localparam int DW = DATA_W + FRACTION_BITS + 1;
	localparam int CW = $clog2(DW);

	logic              busy_q, done_q, neg_q;
	logic [CW-1:0]     cnt_q;
	logic [DW-1:0]     dvd_q;
	logic [DATA_W:0]   rem_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W:0]   rem_sh, rem_nx;
	logic              ge;

	always_comb begin
		rem_sh = {rem_q[DATA_W-1:0], dvd_q[DW-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(DW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DATA_W-1] ^ den[DATA_W-1];
			den_q <= mag32(den);
			rem_q <= '0;
			cnt_q <= '0;
			dvd_q <= (DW'(mag32(num)) << FRACTION_BITS) + DW'(mag32(den) >> 1);
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[DW-2:0], ge};
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign done = done_q;
	assign quo  = sat_mag(neg_q, 64'(dvd_q));

endmodule

// ===== src/ges_datapath.sv =====
// Datapath: matrix RAM, divider, multiply/round/subtract chain, solution
// registers and the output register. Depends on ges_pkg, ges_ram, ges_div.
module ges_datapath import ges_pkg::*; #(
	parameter int MAX_UNKNOWNS  = MAX_UNKNOWNS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int AW            = $clog2(MAX_UNKNOWNS * (MAX_UNKNOWNS + 1)),
	parameter int SW            = $clog2(MAX_UNKNOWNS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	input  logic [AW-1:0]            addr_a,
	input  logic [AW-1:0]            addr_b,
	input  logic [AW-1:0]            waddr,
	input  logic [SW-1:0]            sol_widx,
	input  logic [SW-1:0]            out_ridx,
	input  logic [IDX_W-1:0]         out_index,
	input  logic signed [DATA_W-1:0] coefficient,
	output logic signed [DATA_W-1:0] solution_value,
	output logic [IDX_W-1:0]         solution_index,
	output logic                     singular,
	output logic                     last
);

	localparam int DEPTH = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);

	logic signed [DATA_W-1:0] rda, rdb, wdata, quo, fac_q;
	logic signed [DATA_W-1:0] tgt_s1, tgt_s2, mres_s2;
	logic [63:0]              prod_s1;
	logic                     neg_s1, div_done;
	logic signed [DATA_W-1:0] sol_q [MAX_UNKNOWNS];
	logic                     sing_q [MAX_UNKNOWNS];
	logic signed [DATA_W-1:0] out_value_q;
	logic [IDX_W-1:0]         out_index_q;
	logic                     out_sing_q, out_last_q;

	assign wdata = cmd.wsel_load ? coefficient : sub_sat(tgt_s2, mres_s2);

	ges_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_mat (
		.clk    (clk),
		.we     (cmd.we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (cmd.rd),
		.raddr_a(addr_a),
		.raddr_b(addr_b),
		.rdata_a(rda),
		.rdata_b(rdb)
	);

	ges_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (rdb),
		.den   (rda),
		.done  (div_done),
		.quo   (quo)
	);

	assign stat.piv_zero = (rda == '0);
	assign stat.div_done = div_done;

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(mag32(rda)) * 64'(mag32(fac_q));
		neg_s1  <= rda[DATA_W-1] ^ fac_q[DATA_W-1];
		tgt_s1  <= rdb;
		mres_s2 <= sat_mag(neg_s1, (prod_s1 + (64'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS);
		tgt_s2  <= tgt_s1;

		case (cmd.fac_op)
			FAC_ZERO: fac_q <= '0;
			FAC_DIV:  fac_q <= quo;
			default:  fac_q <= fac_q;
		endcase

		if (cmd.sol_we) begin
			sol_q[sol_widx]  <= (cmd.fac_op == FAC_DIV) ? quo : '0;
			sing_q[sol_widx] <= (cmd.fac_op != FAC_DIV);
		end

		if (cmd.out_load) begin
			out_value_q <= sol_q[out_ridx];
			out_index_q <= out_index;
			out_sing_q  <= sing_q[out_ridx];
			out_last_q  <= cmd.out_last;
		end
	end

	assign solution_value = out_value_q;
	assign solution_index = out_index_q;
	assign singular       = out_sing_q;
	assign last           = out_last_q;

endmodule

// ===== src/ges_ctrl.sv =====
// Controller: load counter, loop counters and sequencing of elimination,
// back substitution and result emission. Depends on ges_pkg.
module ges_ctrl import ges_pkg::*; #(
	parameter int MAX_UNKNOWNS = MAX_UNKNOWNS_DEF,
	parameter int AW           = $clog2(MAX_UNKNOWNS * (MAX_UNKNOWNS + 1)),
	parameter int SW           = $clog2(MAX_UNKNOWNS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_stall,
	output logic              out_valid,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  size_in_use,
	output dp_cmd_t           cmd,
	input  dp_stat_t          stat,
	output logic [AW-1:0]     addr_a,
	output logic [AW-1:0]     addr_b,
	output logic [AW-1:0]     waddr,
	output logic [SW-1:0]     sol_widx,
	output logic [SW-1:0]     out_ridx,
	output logic [IDX_W-1:0]  out_index
);

	localparam int IW = $clog2(MAX_UNKNOWNS + 1);

	state_t           state_q, state_d;
	logic [CFG_W-1:0] size_q;
	logic [AW-1:0]    load_cnt_q, last_idx;
	logic [IW-1:0]    i_q, j_q, k_q, e_q, n, n_m1;
	logic [IW:0]      w;
	logic             phase_q, out_valid_q;
	logic             in_acc, cfg_acc, load_done, out_free;
	logic             k_end, j_end, i_more, bj_end, fac_set, fac_end, e_last;

	function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c,
			input logic [IW:0] wv);
		addr_of = AW'(32'(r) * 32'(wv) + 32'(c));
	endfunction

	always_comb begin
		if (size_q == '0)
			n = IW'(1);
		else if (int'(size_q) > MAX_UNKNOWNS)
			n = IW'(MAX_UNKNOWNS);
		else
			n = IW'(size_q);
		n_m1     = n - IW'(1);
		w        = (IW+1)'(n) + (IW+1)'(1);
		last_idx = AW'(32'(n) * 32'(w) - 32'd1);
	end

	assign in_acc    = in_valid && !in_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign load_done = in_acc && load_cnt_q == last_idx;
	assign out_free  = !out_valid_q || !out_stall;
	assign k_end     = k_q == n;
	assign j_end     = j_q == n_m1;
	assign i_more    = (IW+1)'(i_q) + (IW+1)'(2) < (IW+1)'(n);
	assign bj_end    = (IW+1)'(j_q) + (IW+1)'(1) == (IW+1)'(i_q);
	assign fac_set   = (state_q == ST_CHK && stat.piv_zero) ||
	                   (state_q == ST_DIV && stat.div_done);
	assign fac_end   = phase_q && i_q == '0;
	assign e_last    = e_q == n_m1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (load_done && !cfg_acc)
					state_d = ST_PIV;
			end
			ST_PIV: state_d = ST_CHK;
			ST_CHK: begin
				if (!stat.piv_zero)
					state_d = ST_DIV;
				else
					state_d = fac_end ? ST_EMIT : ST_RD;
			end
			ST_DIV: begin
				if (stat.div_done)
					state_d = fac_end ? ST_EMIT : ST_RD;
			end
			ST_RD:  state_d = ST_MUL;
			ST_MUL: state_d = ST_RND;
			ST_RND: state_d = ST_WR;
			ST_WR: begin
				if (!phase_q)
					state_d = k_end ? ST_PIV : ST_RD;
				else
					state_d = bj_end ? ST_PIV : ST_RD;
			end
			ST_EMIT: begin
				if (out_free && e_last)
					state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.fac_op = FAC_HOLD;
		addr_a    = addr_of(i_q, i_q, w);
		addr_b    = phase_q ? addr_of(i_q, n, w) : addr_of(j_q, i_q, w);
		if (state_q == ST_RD || state_q == ST_MUL || state_q == ST_RND || state_q == ST_WR) begin
			addr_a = phase_q ? addr_of(j_q, i_q, w) : addr_of(i_q, k_q, w);
			addr_b = phase_q ? addr_of(j_q, n, w) : addr_of(j_q, k_q, w);
		end
		waddr = (state_q == ST_LOAD) ? load_cnt_q : addr_b;
		unique case (state_q)
			ST_LOAD: begin
				cmd.we        = in_acc;
				cmd.wsel_load = 1'b1;
			end
			ST_PIV: cmd.rd = 1'b1;
			ST_CHK: begin
				cmd.div_start = !stat.piv_zero;
				cmd.fac_op    = stat.piv_zero ? FAC_ZERO : FAC_HOLD;
				cmd.sol_we    = stat.piv_zero && phase_q;
			end
			ST_DIV: begin
				cmd.fac_op = stat.div_done ? FAC_DIV : FAC_HOLD;
				cmd.sol_we = stat.div_done && phase_q;
			end
			ST_RD: cmd.rd = 1'b1;
			ST_MUL, ST_RND: ;
			ST_WR: cmd.we = 1'b1;
			ST_EMIT: begin
				cmd.out_load = out_free;
				cmd.out_last = e_last;
			end
			default: ;
		endcase
	end

	assign sol_widx  = i_q[SW-1:0];
	assign out_ridx  = e_q[SW-1:0];
	assign out_index = IDX_W'(e_q);
	// a pending size write takes the cycle; the coefficient waits
	assign in_stall  = state_q != ST_LOAD || cfg_valid;
	assign cfg_ready = state_q == ST_LOAD;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			size_q      <= CFG_W'(SIZE_RESET);
			load_cnt_q  <= '0;
			phase_q     <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			e_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (cfg_acc) begin
				size_q     <= size_in_use;
				load_cnt_q <= '0;
			end else if (in_acc) begin
				if (load_done) begin
					load_cnt_q <= '0;
					if (n == IW'(1)) begin
						phase_q <= 1'b1;
						i_q     <= '0;
					end else begin
						phase_q <= 1'b0;
						i_q     <= '0;
						j_q     <= IW'(1);
					end
				end else begin
					load_cnt_q <= load_cnt_q + AW'(1);
				end
			end

			if (fac_set) begin
				k_q <= '0;
				j_q <= phase_q ? '0 : j_q;
				e_q <= '0;
			end

			if (state_q == ST_WR) begin
				if (!phase_q) begin
					if (!k_end) begin
						k_q <= k_q + IW'(1);
					end else if (!j_end) begin
						j_q <= j_q + IW'(1);
					end else if (i_more) begin
						i_q <= i_q + IW'(1);
						j_q <= i_q + IW'(2);
					end else begin
						phase_q <= 1'b1;
						i_q     <= n_m1;
					end
				end else begin
					if (!bj_end)
						j_q <= j_q + IW'(1);
					else
						i_q <= i_q - IW'(1);
				end
			end

			if (cmd.out_load && !e_last)
				e_q <= e_q + IW'(1);
		end
	end

endmodule

// ===== src/gaussian_elimination_solver.sv =====
// Gaussian elimination solver without pivoting, signed fixed point with
// FRACTION_BITS fraction bits. Loads the augmented matrix of n rows by n+1
// columns row-major at one coefficient per cycle. After the last coefficient
// the block stalls its input while it eliminates and back-substitutes, then
// emits the n solutions in index order, the last one marked. Each multiply
// and subtract on a matrix entry steps through ST_RD, ST_MUL, ST_RND and
// ST_WR over the single shared RAM read/write path; each pivot division
// runs in the radix-2 divider (Q16.16 by default). A zero pivot skips the
// division: in elimination the row pair is left unchanged, in back
// substitution the component reads zero with singular set. Products,
// quotients and differences saturate. A write of size_in_use restarts the
// load; the input is stalled while a size write is offered.
// Depends on ges_pkg, ges_ctrl, ges_datapath.
module gaussian_elimination_solver import ges_pkg::*; #(
	parameter int MAX_UNKNOWNS  = MAX_UNKNOWNS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] coefficient,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] solution_value,
	output logic [IDX_W-1:0]         solution_index,
	output logic                     singular,
	output logic                     last,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_W-1:0]         size_in_use
);

	localparam int AW = $clog2(MAX_UNKNOWNS * (MAX_UNKNOWNS + 1));
	localparam int SW = $clog2(MAX_UNKNOWNS);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [AW-1:0]    addr_a, addr_b, waddr;
	logic [SW-1:0]    sol_widx, out_ridx;
	logic [IDX_W-1:0] out_index;

	ges_ctrl #(
		.MAX_UNKNOWNS(MAX_UNKNOWNS),
		.AW          (AW),
		.SW          (SW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.size_in_use(size_in_use),
		.cmd        (cmd),
		.stat       (stat),
		.addr_a     (addr_a),
		.addr_b     (addr_b),
		.waddr      (waddr),
		.sol_widx   (sol_widx),
		.out_ridx   (out_ridx),
		.out_index  (out_index)
	);

	ges_datapath #(
		.MAX_UNKNOWNS (MAX_UNKNOWNS),
		.FRACTION_BITS(FRACTION_BITS),
		.AW           (AW),
		.SW           (SW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.addr_a        (addr_a),
		.addr_b        (addr_b),
		.waddr         (waddr),
		.sol_widx      (sol_widx),
		.out_ridx      (out_ridx),
		.out_index     (out_index),
		.coefficient   (coefficient),
		.solution_value(solution_value),
		.solution_index(solution_index),
		.singular      (singular),
		.last          (last)
	);

	// a taken component that is not the last is followed at once by the next
	a_next_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("result stream broke before last");

	a_next_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
		solution_index == IDX_W'($past(solution_index) + IDX_W'(1)))
		else $error("solution index did not advance by one");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid)
		else $error("result after last component");

endmodule

// ===== tb/tb_gaussian_elimination_solver.sv =====
// Testbench for gaussian_elimination_solver: loads augmented matrices through the
// coefficient stream and checks every emitted solution component against a built-in
// fixed-point solver. Depends on ges_pkg and the solver RTL.
`timescale 1ns / 100ps

module tb_gaussian_elimination_solver;
	import ges_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int FRAC           = FRACTION_BITS_DEF;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         index;
		logic                     sing;
		logic                     last_flag;
	} solution_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [DATA_W-1:0] coefficient;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] solution_value;
	logic [IDX_W-1:0]         solution_index;
	logic                     singular;
	logic                     last;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_W-1:0]         size_in_use;

	solution_t   pending_solutions[$];
	int          error_count;
	int          items_sent;
	int          solutions_seen;
	int          idle_cycles;
	int          rx_hold;
	int          rx_burst;
	bit          quiet;
	logic [CFG_W-1:0] size_reg;
	int          load_pos;
	logic signed [DATA_W-1:0] mat[MAX_UNKNOWNS_DEF*(MAX_UNKNOWNS_DEF+1)];

	gaussian_elimination_solver dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .coefficient(coefficient),
		.out_valid(out_valid), .out_stall(out_stall),
		.solution_value(solution_value), .solution_index(solution_index),
		.singular(singular), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .size_in_use(size_in_use)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] fx_saturate(bit neg, longint unsigned mag);
		if (neg) begin
			if (mag >= 64'h8000_0000)
				return 32'sh8000_0000;
			return 32'(-longint'(mag));
		end
		if (mag > 64'h7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		return 32'(mag);
	endfunction

	function automatic longint unsigned fx_abs(logic signed [31:0] a);
		longint s;
		s = a;
		return (s < 0) ? longint'(-s) : longint'(s);
	endfunction

	function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
		longint unsigned p;
		p = fx_abs(a) * fx_abs(b);
		return fx_saturate((a < 0) != (b < 0), (p + (64'd1 << (FRAC - 1))) >> FRAC);
	endfunction

	function automatic logic signed [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] b);
		longint unsigned num, den;
		num = fx_abs(a) << FRAC;
		den = fx_abs(b);
		return fx_saturate((a < 0) != (b < 0), (num + den / 2) / den);
	endfunction

	function automatic logic signed [31:0] fx_sub(logic signed [31:0] a, logic signed [31:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d > 64'sh7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (d < -64'sh8000_0000)
			return 32'sh8000_0000;
		return 32'(d);
	endfunction

	function automatic int unknowns();
		if (size_reg == 0)
			return 1;
		if (size_reg > MAX_UNKNOWNS_DEF)
			return MAX_UNKNOWNS_DEF;
		return int'(size_reg);
	endfunction

	function automatic void solve_system();
		int n, w;
		logic signed [31:0] piv, v, x;
		bit sing[MAX_UNKNOWNS_DEF];
		logic signed [31:0] xs[MAX_UNKNOWNS_DEF];
		solution_t s;
		n = unknowns();
		w = n + 1;
		for (int i = 0; i < n; i++) begin
			piv = mat[i*w+i];
			for (int j = i + 1; j < n; j++) begin
				v = (piv != 0) ? fx_div(mat[j*w+i], piv) : 32'sd0;
				for (int k = 0; k < w; k++)
					mat[j*w+k] = fx_sub(mat[j*w+k], fx_mul(mat[i*w+k], v));
			end
		end
		for (int i = n - 1; i >= 0; i--) begin
			piv = mat[i*w+i];
			if (piv != 0) begin
				x = fx_div(mat[i*w+n], piv);
				sing[i] = 1'b0;
			end else begin
				x = 0;
				sing[i] = 1'b1;
			end
			xs[i] = x;
			for (int j = 0; j < i; j++)
				mat[j*w+n] = fx_sub(mat[j*w+n], fx_mul(x, mat[j*w+i]));
		end
		for (int i = 0; i < n; i++) begin
			s.value = xs[i];
			s.index = IDX_W'(i);
			s.sing = sing[i];
			s.last_flag = (i == n - 1);
			pending_solutions.push_back(s);
		end
	endfunction

	function automatic void load_coefficient(logic signed [31:0] c);
		int n;
		n = unknowns();
		if (load_pos >= n * (n + 1))
			load_pos = 0;
		mat[load_pos] = c;
		load_pos++;
		if (load_pos == n * (n + 1)) begin
			load_pos = 0;
			solve_system();
		end
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// in_valid stays high across back-to-back transactions, except for random idle gaps when not quiet
	task automatic send_coefficient(logic signed [31:0] c);
		bit s;
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coefficient <= c;
		do begin
			@(negedge clk);
			s = in_stall;
			@(posedge clk);
		end while (s);
		load_coefficient(c);
		items_sent++;
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		stop_sending();
		while (pending_solutions.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_size(logic [CFG_W-1:0] v);
		bit r;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		size_in_use <= v;
		do begin
			@(negedge clk);
			r = cfg_ready;
			@(posedge clk);
		end while (!r);
		cfg_valid <= 1'b0;
		size_reg = v;
		load_pos = 0;
	endtask

	function automatic logic signed [31:0] random_coefficient(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
			default: return ($urandom_range(0, 3) == 0) ? 32'sd0 : 32'($urandom_range(1, 3) << FRAC);
		endcase
	endfunction

	task automatic send_matrix(int mode);
		int n;
		n = unknowns();
		for (int r = 0; r < n; r++)
			for (int c = 0; c <= n; c++)
				send_coefficient((mode == 1 && r == c && $urandom_range(0, 1)) ?
					32'(($urandom_range(8, 20)) << FRAC) : random_coefficient(mode));
	endtask

	task automatic test_single_unknown();
		write_size(4'd1);
		send_coefficient(32'sh7FFF_FFFF);
		send_coefficient(32'sh8000_0000);
		send_coefficient(32'sh8000_0000);
		send_coefficient(32'sh0000_0001);
		write_size(4'd0);
		send_coefficient(32'sd0);
		send_coefficient(32'sh0003_0000);
	endtask

	task automatic test_zero_pivots();
		write_size(4'd2);
		// zero first pivot: elimination of row 1 skipped
		send_coefficient(0); send_coefficient(32'sh0001_0000); send_coefficient(32'sh0002_0000);
		send_coefficient(32'sh0001_0000); send_coefficient(32'sh0001_0000);
		send_coefficient(32'sh0005_0000);
		// dependent rows: zero pivot in back substitution
		send_coefficient(32'sh0001_0000); send_coefficient(32'sh0002_0000);
		send_coefficient(32'sh0003_0000); send_coefficient(32'sh0002_0000);
		send_coefficient(32'sh0004_0000); send_coefficient(32'sh0001_0000);
	endtask

	task automatic test_load_restart();
		send_coefficient(32'sh1234_5678);
		send_coefficient(32'shFFFF_0000);
		send_coefficient(32'sh0000_8000);
		write_size(4'd2);
		send_matrix(1);
	endtask

	// size above the maximum clamps to eight unknowns
	task automatic test_large_sizes();
		write_size(4'd15);
		send_matrix(1);
	endtask

	task automatic test_backpressure();
		write_size(4'd2);
		rx_hold = 600;
		repeat (3) send_matrix(1);
		wait_drained();
	endtask

	task automatic test_random_systems();
		logic [CFG_W-1:0] sz;
		while (items_sent < 140) begin
			sz = CFG_W'($urandom_range(1, 4));
			if (sz != size_reg || $urandom_range(0, 3) == 0)
				write_size(sz);
			send_matrix($urandom_range(0, 5) == 0 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1));
		end
	endtask

	task automatic test_quiet_tail();
		quiet = 1'b1;
		write_size(4'd3);
		repeat (2) send_matrix(1);
		send_matrix(0);
	endtask

	// result side stall: random bursts, plus a long hold on request
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			out_stall <= 1'b1;
		end else if (rx_burst > 0) begin
			rx_burst <= rx_burst - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			rx_burst <= $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		solution_t want;
		if (arst_n && out_valid && !out_stall) begin
			solutions_seen++;
			if (pending_solutions.size() == 0) begin
				report_mismatch("unexpected solution, index", solution_index, -1);
			end else begin
				want = pending_solutions.pop_front();
				if (solution_value !== want.value)
					report_mismatch("solution_value", solution_value, want.value);
				if (solution_index !== want.index)
					report_mismatch("solution_index", solution_index, want.index);
				if (singular !== want.sing)
					report_mismatch("singular", singular, want.sing);
				if (last !== want.last_flag)
					report_mismatch("last", last, want.last_flag);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		coefficient = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		size_in_use = '0;
		error_count = 0;
		items_sent = 0;
		solutions_seen = 0;
		idle_cycles = 0;
		rx_hold = 0;
		rx_burst = 0;
		quiet = 1'b0;
		size_reg = CFG_W'(SIZE_RESET);
		load_pos = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_unknown();
		test_zero_pivots();
		test_load_restart();
		test_backpressure();
		test_large_sizes();
		test_random_systems();
		test_quiet_tail();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("solved systems of 1 to 8 unknowns incl. zero pivots, size clamping,");
		$display("load restart and backpressure: %0d coefficients, %0d solutions checked",
			items_sent, solutions_seen);
		if (error_count == 0 && pending_solutions.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
